// File: rtl/rvs_pkg.sv
// ----------------------------------------------------------------------------
// Random victim selector package
// Shared constants, widths and types for the victim selector and its parts.
// ----------------------------------------------------------------------------
package rvs_pkg;

  localparam int unsigned StateW  = 32;
  localparam int unsigned IdW     = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned MulW    = 17;
  localparam int unsigned StepW   = $clog2(StateW);

  // Generator multiplier and prime modulus 2^32-5.
  localparam logic [MulW-1:0]   RngMul     = MulW'(69070);
  localparam logic [StateW-1:0] RngMod     = 32'hFFFF_FFFB;
  localparam logic [CountW-1:0] MaxWorkers = CountW'(64);

  // Command codes of an input word.
  localparam logic CmdSeed = 1'b0;
  localparam logic CmdDraw = 1'b1;

  // Configuration register indexes.
  localparam logic CfgWorkerCount = 1'b0;
  localparam logic CfgSelfId      = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StMod,
    StOut
  } rvs_state_e;

endpackage

// File: rtl/rvs_in_if.sv
// ----------------------------------------------------------------------------
// Victim selector request channel
// Valid/ready channel carrying a command and a seed.
// ----------------------------------------------------------------------------
interface rvs_in_if;
  import rvs_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [StateW-1:0] seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface

// File: rtl/rvs_out_if.sv
// ----------------------------------------------------------------------------
// Victim selector result channel
// Valid/ready channel carrying the chosen victim and the new generator state.
// ----------------------------------------------------------------------------
interface rvs_out_if;
  import rvs_pkg::*;

  logic              valid;
  logic              ready;
  logic [IdW-1:0]    victim_id;
  logic [StateW-1:0] random_value;

  modport source (output valid, output victim_id, output random_value, input ready);
  modport sink   (input valid, input victim_id, input random_value, output ready);
endinterface

// File: rtl/random_victim_selector.sv
// ----------------------------------------------------------------------------
// Random victim selector
// Multiplicative congruential generator (x * 69070 mod 2^32-5) choosing a
// random worker other than this one.
//
// Usage:
//   in_i  : request words. cmd = seed loads seed_value mod 2^32-5 (0 becomes
//           1) and gives no result. cmd = draw advances the generator and
//           gives one result word on out_o.
//   out_o : victim_id and random_value (the new generator state).
//   cfg   : cfg_we_i writes cfg_wdata_i to worker_count (index 0) or
//           self_id (index 1); write only while no draw is in flight.
// Sequence: a seed loads the generator state when it is accepted. A draw runs
//   the bit-serial modular multiplier, a handoff through its done register,
//   the bit-serial remainder by worker_count-1 (worker_count capped at 64),
//   then loads the output register. The next word is accepted in the cycle
//   after that load, so a draw is finished before the next word is taken.
// The output register holds a result until it is taken; in_i accepts the
//   next word meanwhile, and a following draw waits only at its end if the
//   previous result has still not been taken.
// Reset: generator state 1, worker_count 2, self_id 0, no result pending.
// ----------------------------------------------------------------------------
module random_victim_selector
  import rvs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  rvs_in_if.sink          in_i,
  rvs_out_if.source       out_o
);

  rvs_state_e state_q, state_d;

  logic [CountW-1:0] worker_count_q;
  logic [IdW-1:0]    self_id_q;
  logic [StateW-1:0] rng_q;

  logic              in_ready;
  logic              in_fire;
  logic              mul_start;
  logic              mul_done;
  logic [StateW-1:0] mul_result;
  logic              out_load;
  logic              out_free;

  logic [StateW-1:0] mod_shift_q;
  logic [IdW-1:0]    rem_q, rem_d;
  logic [StepW-1:0]  mod_cnt_q;
  logic [IdW-1:0]    div_q;
  logic              few_q;
  logic [CountW-1:0] n_sat;
  logic [IdW:0]      trial;

  logic              out_valid_q;
  logic [IdW-1:0]    victim_q, victim_d;
  logic [StateW-1:0] value_q;
  logic [StateW-1:0] seed_red;

  assign in_fire  = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire && (in_i.cmd == CmdDraw)) begin
          state_d = StMul;
        end
      end
      StMul: begin
        if (mul_done) begin
          state_d = StMod;
        end
      end
      StMod: begin
        if (mod_cnt_q == '1) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready  = 1'b1;
        mul_start = in_fire && (in_i.cmd == CmdDraw);
      end
      StOut: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_count_q <= CountW'(2);
      self_id_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWorkerCount: worker_count_q <= cfg_wdata_i[CountW-1:0];
        CfgSelfId:      self_id_q      <= cfg_wdata_i[IdW-1:0];
        default: ;
      endcase
    end
  end

  // A seed is below 2*M, so one subtraction reduces it.
  always_comb begin
    if (in_i.seed_value >= RngMod) begin
      seed_red = in_i.seed_value - RngMod;
    end else begin
      seed_red = in_i.seed_value;
    end
    if (seed_red == '0) begin
      seed_red = StateW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q <= StateW'(1);
    end else if (in_fire && (in_i.cmd == CmdSeed)) begin
      rng_q <= seed_red;
    end else if (mul_done) begin
      rng_q <= mul_result;
    end
  end

  rvs_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (rng_q),
    .done_o    (mul_done),
    .result_o  (mul_result)
  );

  assign n_sat = (worker_count_q > MaxWorkers) ? MaxWorkers : worker_count_q;

  // Restoring remainder step: r = (2*r + bit) mod d, with r below d whenever d is nonzero.
  always_comb begin
    trial = {rem_q, mod_shift_q[StateW-1]};
    if (trial >= {1'b0, div_q}) begin
      trial = trial - {1'b0, div_q};
    end
    rem_d = trial[IdW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_cnt_q <= '0;
    end else if (mul_done) begin
      mod_cnt_q <= '0;
    end else if (state_q == StMod) begin
      mod_cnt_q <= mod_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_done) begin
      mod_shift_q <= mul_result;
      rem_q       <= '0;
      few_q       <= (n_sat < CountW'(2));
      div_q       <= IdW'(n_sat - CountW'(1));
    end else if (state_q == StMod) begin
      mod_shift_q <= {mod_shift_q[StateW-2:0], 1'b0};
      rem_q       <= rem_d;
    end
  end

  // Skip over this worker's own id; with fewer than two workers the victim is 0.
  always_comb begin
    if (few_q) begin
      victim_d = '0;
    end else if (rem_q >= self_id_q) begin
      victim_d = rem_q + 1'b1;
    end else begin
      victim_d = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      victim_q <= victim_d;
      value_q  <= rng_q;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.victim_id    = victim_q;
  assign out_o.random_value = value_q;

endmodule

// File: rtl/rvs_mulmod.sv
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Computes operand * 69070 mod (2^32-5), one operand bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rvs_mulmod
  import rvs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [StateW-1:0] operand_i,
  output logic              done_o,
  output logic [StateW-1:0] result_o
);

  localparam logic [StateW+1:0] Mod1 = (StateW+2)'(RngMod);
  localparam logic [StateW+1:0] Mod2 = {1'b0, RngMod, 1'b0};

  logic [StateW-1:0] shift_q;
  logic [StateW-1:0] acc_q, acc_d;
  logic [StepW-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [StateW+1:0] sum;

  // Horner step: acc = (2*acc + bit*K) mod M. The sum stays below 3*M,
  // so at most two subtractions of M are needed.
  always_comb begin
    sum = {1'b0, acc_q, 1'b0};
    if (shift_q[StateW-1]) begin
      sum = sum + (StateW+2)'(RngMul);
    end
    if (sum >= Mod2) begin
      acc_d = StateW'(sum - Mod2);
    end else if (sum >= Mod1) begin
      acc_d = StateW'(sum - Mod1);
    end else begin
      acc_d = StateW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= operand_i;
      acc_q   <= '0;
    end else if (busy_q) begin
      shift_q <= {shift_q[StateW-2:0], 1'b0};
      acc_q   <= acc_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule
